// ===== hdl/fpc_pkg.sv =====
// Shared types, constants and the input grading function for the fuzzy pH pump controller.
package fpc_pkg;

  localparam int PH_W          = 12;
  localparam int ERR_W         = 13;
  localparam int MU_W          = 17;
  localparam int PCT_W         = 15;
  localparam int NUM_IN        = 7;
  localparam int NUM_OUT       = 5;
  localparam int PCT_FULL      = 25600;
  localparam int SAMPLE_POINTS = 21;
  localparam int RCP_W         = 22;
  localparam int RCP_SH        = 24;

  typedef logic signed [ERR_W-1:0]    err_t;
  typedef logic [MU_W-1:0]            mu_t;
  typedef logic [PCT_W-1:0]           pct_t;
  typedef logic [NUM_OUT-1:0][MU_W-1:0] str_t;

  localparam mu_t         MU_ONE       = 17'h10000;
  localparam err_t        ERR_LIMIT    = 13'sd1536;
  localparam logic [PH_W-1:0] SETPOINT_RST = 12'd1792;

  // Input sets, in the order AA, MA, BA, N, BB, MB, AB.
  localparam err_t IN_A [NUM_IN] = '{-13'sd1536, -13'sd1536, -13'sd1024, -13'sd128,
                                     13'sd0, 13'sd768, 13'sd1152};
  localparam err_t IN_B [NUM_IN] = '{-13'sd1536, -13'sd1024, -13'sd512, 13'sd0,
                                     13'sd512, 13'sd1024, 13'sd1280};
  localparam err_t IN_C [NUM_IN] = '{-13'sd1408, -13'sd1024, -13'sd512, 13'sd0,
                                     13'sd512, 13'sd1024, 13'sd1536};
  localparam err_t IN_D [NUM_IN] = '{-13'sd1152, -13'sd768, 13'sd0, 13'sd128,
                                     13'sd1024, 13'sd1536, 13'sd1536};
  // Every input edge width is a power of two, so grading is a shift.
  localparam int IN_SL [NUM_IN] = '{0, 9, 9, 7, 9, 8, 7};
  localparam int IN_SR [NUM_IN] = '{8, 8, 9, 7, 9, 9, 0};

  // Output sets, in the order OFF, BP, MBP, MAP, ALL.
  localparam pct_t OUT_A [NUM_OUT] = '{15'd0, 15'd0, 15'd7680, 15'd15360, 15'd25600};
  localparam pct_t OUT_B [NUM_OUT] = '{15'd0, 15'd2560, 15'd10240, 15'd17920, 15'd25600};
  localparam pct_t OUT_C [NUM_OUT] = '{15'd0, 15'd2560, 15'd10240, 15'd17920, 15'd25600};
  localparam pct_t OUT_D [NUM_OUT] = '{15'd0, 15'd10240, 15'd12800, 15'd23040, 15'd25600};

  // Every sloped output edge is 512 times 5, 10 or 15 wide. The grade is then
  // floor(distance * 128 / k), taken as (distance * 128 * ceil(2^24 / k)) >> 24,
  // which is exact over each edge. Flat or single-point sides carry zero.
  localparam logic [RCP_W-1:0] OUT_RL [NUM_OUT] = '{22'd0, 22'd3355444, 22'd3355444,
                                                    22'd3355444, 22'd0};
  localparam logic [RCP_W-1:0] OUT_RR [NUM_OUT] = '{22'd0, 22'd1118482, 22'd3355444,
                                                    22'd1677722, 22'd0};

  // Consequent of each input set for the two pumps.
  localparam logic [2:0] ETH_MAP [NUM_IN] = '{3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0};
  localparam logic [2:0] WAT_MAP [NUM_IN] = '{3'd0, 3'd0, 3'd0, 3'd1, 3'd3, 3'd2, 3'd4};

  // Grade of the clamped error against one input set.
  function automatic mu_t in_grade(input int k, input err_t e);
    logic [9:0] ofs;
    mu_t        g;
    ofs = '0;
    g   = '0;
    if (e < IN_A[k] || e > IN_D[k]) begin
      g = '0;
    end else if (e >= IN_B[k] && e <= IN_C[k]) begin
      g = MU_ONE;
    end else if (e < IN_B[k]) begin
      ofs = 10'(e - IN_A[k]);
      g   = MU_W'({ofs, 16'b0} >> IN_SL[k]);
    end else begin
      ofs = 10'(IN_D[k] - e);
      g   = MU_W'({ofs, 16'b0} >> IN_SR[k]);
    end
    return g;
  endfunction

endpackage

// ===== hdl/fpc_div.sv =====
// Bit-serial restoring divider for the two centroid quotients.
module fpc_div #(
  parameter int DVD_W = 40,
  parameter int DSR_W = 23,
  parameter int CNT_W = $clog2(DVD_W + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  input  logic [CNT_W-1:0] nbits,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DSR_W-1:0] dsr_r, dsr_nxt;
  logic [DSR_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DSR_W:0]   trial;

  // One quotient bit per cycle, dividend consumed from the top.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    trial    = {rem_r, dvd_r[DVD_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = nbits;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      q_nxt    = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DSR_W'(trial - {1'b0, dsr_r});
        q_nxt   = {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DSR_W-1:0];
        q_nxt   = {q_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== hdl/fpc_fuzz.sv =====
// Error computation, fuzzification and rule strengths per output set.
module fpc_fuzz (
  input  logic                    clk,
  input  logic                    load,
  input  logic [fpc_pkg::PH_W-1:0] setpoint,
  input  logic [fpc_pkg::PH_W-1:0] measured,
  output fpc_pkg::str_t           str_eth,
  output fpc_pkg::str_t           str_wat
);

  fpc_pkg::err_t diff;
  fpc_pkg::err_t err;
  fpc_pkg::mu_t  grades [fpc_pkg::NUM_IN];
  fpc_pkg::str_t eth_nxt, wat_nxt;
  fpc_pkg::str_t eth_r, wat_r;

  // Saturated error, setpoint minus measurement.
  always_comb begin
    diff = fpc_pkg::err_t'({1'b0, setpoint}) - fpc_pkg::err_t'({1'b0, measured});
    if (diff > fpc_pkg::ERR_LIMIT) begin
      err = fpc_pkg::ERR_LIMIT;
    end else if (diff < -fpc_pkg::ERR_LIMIT) begin
      err = -fpc_pkg::ERR_LIMIT;
    end else begin
      err = diff;
    end
  end

  // Grades of the seven input sets, then max per consequent set.
  always_comb begin
    eth_nxt = '0;
    wat_nxt = '0;
    for (int k = 0; k < fpc_pkg::NUM_IN; k++) begin
      grades[k] = fpc_pkg::in_grade(k, err);
    end
    for (int k = 0; k < fpc_pkg::NUM_IN; k++) begin
      if (grades[k] > eth_nxt[fpc_pkg::ETH_MAP[k]]) begin
        eth_nxt[fpc_pkg::ETH_MAP[k]] = grades[k];
      end
      if (grades[k] > wat_nxt[fpc_pkg::WAT_MAP[k]]) begin
        wat_nxt[fpc_pkg::WAT_MAP[k]] = grades[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      eth_r <= eth_nxt;
      wat_r <= wat_nxt;
    end
  end

  assign str_eth = eth_r;
  assign str_wat = wat_r;

endmodule

// ===== hdl/fuzzy_ph_pump_controller.sv =====
// Top level of the fuzzy pH pump controller: sequencer, accumulators and output register.
// Each transfer of a pH sample yields one result transfer holding both pump drives.
// The block takes one sample at a time and holds in_stall high until the result
// has been taken. Each sample point takes five output-set grades, one multiply
// and two accumulations. Sloped output grades come from a reciprocal
// multiplication; only the two centroid divisions use the bit-serial divider,
// and each division is skipped when its total membership is zero. The pH
// setpoint may be written at any time the block is idle and resets to 7.0 pH.
module fuzzy_ph_pump_controller #(
  parameter int SAMPLE_POINTS = fpc_pkg::SAMPLE_POINTS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [fpc_pkg::PH_W-1:0]   cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [fpc_pkg::PH_W-1:0]   in_measured_ph,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [fpc_pkg::PCT_W-1:0]  out_ethanol_power,
  output logic [fpc_pkg::PCT_W-1:0]  out_water_power
);

  localparam int SPAN   = SAMPLE_POINTS - 1;
  localparam int STEP_Q = fpc_pkg::PCT_FULL / SPAN;
  localparam int STEP_R = fpc_pkg::PCT_FULL % SPAN;
  localparam int REM_W  = $clog2(2 * SPAN);
  localparam int IDX_W  = $clog2(SAMPLE_POINTS);
  localparam int NUM_W  = $clog2(longint'(SAMPLE_POINTS) * 25600 * 65536 + 1);
  localparam int DEN_W  = $clog2(SAMPLE_POINTS * 65536 + 1);
  localparam int DVD_W  = NUM_W + 1;
  localparam int CNT_W  = $clog2(DVD_W + 1);
  localparam int PRD_W  = fpc_pkg::PCT_W + fpc_pkg::MU_W;
  localparam int GPR_W  = 13 + 7 + fpc_pkg::RCP_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SET   = 4'd1;
  localparam logic [3:0] ST_MULE  = 4'd2;
  localparam logic [3:0] ST_ACCE  = 4'd3;
  localparam logic [3:0] ST_ACCW  = 4'd4;
  localparam logic [3:0] ST_DIVE  = 4'd5;
  localparam logic [3:0] ST_WAITE = 4'd6;
  localparam logic [3:0] ST_DIVW  = 4'd7;
  localparam logic [3:0] ST_WAITW = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [3:0]                 state_r, state_nxt;
  logic [fpc_pkg::PH_W-1:0]   setpoint_r;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic [2:0]                 set_r, set_nxt;
  fpc_pkg::pct_t              x_r, x_nxt;
  logic [REM_W-1:0]           xrem_r, xrem_nxt;
  logic [REM_W-1:0]           xrem_sum;
  fpc_pkg::mu_t               mu_e_r, mu_e_nxt, mu_w_r, mu_w_nxt;
  logic [PRD_W-1:0]           prod_r, prod_nxt;
  logic [NUM_W-1:0]           num_e_r, num_e_nxt, num_w_r, num_w_nxt;
  logic [DEN_W-1:0]           den_e_r, den_e_nxt, den_w_r, den_w_nxt;
  fpc_pkg::pct_t              res_e_r, res_e_nxt, res_w_r, res_w_nxt;
  logic                       accept;
  fpc_pkg::str_t              str_eth, str_wat;
  fpc_pkg::mu_t               go;
  fpc_pkg::mu_t               se, sw;
  logic                       slope;
  logic [12:0]                edge_d;
  logic [fpc_pkg::RCP_W-1:0]  rcp;
  logic [GPR_W-1:0]           gprod;
  logic                       div_start;
  logic [DVD_W-1:0]           div_dividend;
  logic [DEN_W-1:0]           div_divisor;
  logic [CNT_W-1:0]           div_nbits;
  logic                       div_busy, div_done;
  logic [DVD_W-1:0]           div_q;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  fpc_fuzz u_fuzz (
    .clk      (clk),
    .load     (accept),
    .setpoint (setpoint_r),
    .measured (in_measured_ph),
    .str_eth  (str_eth),
    .str_wat  (str_wat)
  );

  fpc_div #(
    .DVD_W (DVD_W),
    .DSR_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .nbits    (div_nbits),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Grade the current sample point against the current output set; a sloped
  // edge is divided by its constant width through a reciprocal multiplication.
  always_comb begin
    slope  = 1'b0;
    edge_d = '0;
    rcp    = '0;
    go     = '0;
    if (x_r < fpc_pkg::OUT_A[set_r] || x_r > fpc_pkg::OUT_D[set_r]) begin
      go = '0;
    end else if (x_r >= fpc_pkg::OUT_B[set_r] && x_r <= fpc_pkg::OUT_C[set_r]) begin
      go = fpc_pkg::MU_ONE;
    end else if (x_r < fpc_pkg::OUT_B[set_r]) begin
      slope  = 1'b1;
      edge_d = 13'(x_r - fpc_pkg::OUT_A[set_r]);
      rcp    = fpc_pkg::OUT_RL[set_r];
    end else begin
      slope  = 1'b1;
      edge_d = 13'(fpc_pkg::OUT_D[set_r] - x_r);
      rcp    = fpc_pkg::OUT_RR[set_r];
    end
    gprod = GPR_W'({edge_d, 7'b0}) * GPR_W'(rcp);
    if (slope) begin
      go = gprod[fpc_pkg::RCP_SH +: fpc_pkg::MU_W];
    end
    se = str_eth[set_r];
    sw = str_wat[set_r];
  end

  // Divider request for one of the two centroids.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DVD_W'(num_e_r) + DVD_W'(den_e_r >> 1);
    div_divisor  = den_e_r;
    div_nbits    = CNT_W'(DVD_W);
    unique case (state_r)
      ST_DIVE: begin
        div_start = (den_e_r != '0);
      end
      ST_DIVW: begin
        div_start    = (den_w_r != '0);
        div_dividend = DVD_W'(num_w_r) + DVD_W'(den_w_r >> 1);
        div_divisor  = den_w_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Sequencer over sample points and output sets.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    set_nxt   = set_r;
    x_nxt     = x_r;
    xrem_nxt  = xrem_r;
    mu_e_nxt  = mu_e_r;
    mu_w_nxt  = mu_w_r;
    prod_nxt  = prod_r;
    num_e_nxt = num_e_r;
    num_w_nxt = num_w_r;
    den_e_nxt = den_e_r;
    den_w_nxt = den_w_r;
    res_e_nxt = res_e_r;
    res_w_nxt = res_w_r;
    xrem_sum  = xrem_r + REM_W'(STEP_R);
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SET;
          idx_nxt   = '0;
          set_nxt   = '0;
          x_nxt     = '0;
          xrem_nxt  = '0;
          mu_e_nxt  = '0;
          mu_w_nxt  = '0;
          num_e_nxt = '0;
          num_w_nxt = '0;
          den_e_nxt = '0;
          den_w_nxt = '0;
        end
      end
      ST_SET: begin
        mu_e_nxt = ((se < go) ? se : go) > mu_e_r ? ((se < go) ? se : go) : mu_e_r;
        mu_w_nxt = ((sw < go) ? sw : go) > mu_w_r ? ((sw < go) ? sw : go) : mu_w_r;
        if (set_r == 3'(fpc_pkg::NUM_OUT - 1)) begin
          state_nxt = ST_MULE;
        end else begin
          set_nxt   = set_r + 1'b1;
          state_nxt = ST_SET;
        end
      end
      ST_MULE: begin
        prod_nxt  = PRD_W'(x_r) * PRD_W'(mu_e_r);
        state_nxt = ST_ACCE;
      end
      ST_ACCE: begin
        num_e_nxt = num_e_r + NUM_W'(prod_r);
        den_e_nxt = den_e_r + DEN_W'(mu_e_r);
        prod_nxt  = PRD_W'(x_r) * PRD_W'(mu_w_r);
        state_nxt = ST_ACCW;
      end
      ST_ACCW: begin
        num_w_nxt = num_w_r + NUM_W'(prod_r);
        den_w_nxt = den_w_r + DEN_W'(mu_w_r);
        mu_e_nxt  = '0;
        mu_w_nxt  = '0;
        set_nxt   = '0;
        if (idx_r == IDX_W'(SPAN)) begin
          state_nxt = ST_DIVE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          // Next point: add quotient and remainder of the step separately.
          if (xrem_sum >= REM_W'(SPAN)) begin
            xrem_nxt = xrem_sum - REM_W'(SPAN);
            x_nxt    = x_r + fpc_pkg::PCT_W'(STEP_Q) + 1'b1;
          end else begin
            xrem_nxt = xrem_sum;
            x_nxt    = x_r + fpc_pkg::PCT_W'(STEP_Q);
          end
          state_nxt = ST_SET;
        end
      end
      ST_DIVE: begin
        if (den_e_r == '0) begin
          res_e_nxt = '0;
          state_nxt = ST_DIVW;
        end else begin
          state_nxt = ST_WAITE;
        end
      end
      ST_WAITE: begin
        if (div_done) begin
          res_e_nxt = div_q[fpc_pkg::PCT_W-1:0];
          state_nxt = ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (den_w_r == '0) begin
          res_w_nxt = '0;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_WAITW;
        end
      end
      ST_WAITW: begin
        if (div_done) begin
          res_w_nxt = div_q[fpc_pkg::PCT_W-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state and the setpoint register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      setpoint_r <= fpc_pkg::SETPOINT_RST;
      idx_r      <= '0;
      set_r      <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      set_r   <= set_nxt;
      if (cfg_wr_en) begin
        setpoint_r <= cfg_wr_data;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    xrem_r  <= xrem_nxt;
    mu_e_r  <= mu_e_nxt;
    mu_w_r  <= mu_w_nxt;
    prod_r  <= prod_nxt;
    num_e_r <= num_e_nxt;
    num_w_r <= num_w_nxt;
    den_e_r <= den_e_nxt;
    den_w_r <= den_w_nxt;
    res_e_r <= res_e_nxt;
    res_w_r <= res_w_nxt;
  end

  assign out_ethanol_power = res_e_r;
  assign out_water_power   = res_w_r;

`ifndef SYNTHESIS
  // The divider is never restarted while it is still working.
  assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_busy)
    else $error("divider started while busy");
  // The point index never passes the last sample point.
  assert property (@(posedge clk) disable iff (!rst_n) idx_r <= IDX_W'(SPAN))
    else $error("sample point index out of range");
  // A finished divider result arrives only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_WAITE || state_r == ST_WAITW))
    else $error("divider result arrived with nobody waiting");
  // The output set counter stays within the five output sets.
  assert property (@(posedge clk) disable iff (!rst_n) set_r <= 3'(fpc_pkg::NUM_OUT - 1))
    else $error("output set index out of range");
`endif

endmodule

// ===== tb/fpc_checker.sv =====
// Checker for the fuzzy pH pump controller: predicts pump drives and compares transfers.
module fpc_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [fpc_pkg::PH_W-1:0]  cfg_wr_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [fpc_pkg::PH_W-1:0]  in_measured_ph,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [fpc_pkg::PCT_W-1:0] out_ethanol_power,
  input  logic [fpc_pkg::PCT_W-1:0] out_water_power,
  output int                        fail_count,
  output int                        drives_pending,
  output int                        drives_checked,
  output int                        transfers_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    fpc_pkg::pct_t ethanol;
    fpc_pkg::pct_t water;
  } drive_pair_t;

  localparam longint GRADE_ONE = 65536;
  localparam int NUM_POINTS = 21;

  // Error sets AA, MA, BA, N, BB, MB, AB as corner points.
  localparam int ERR_A [7] = '{-1536, -1536, -1024, -128,    0,  768, 1152};
  localparam int ERR_B [7] = '{-1536, -1024,  -512,    0,  512, 1024, 1280};
  localparam int ERR_C [7] = '{-1408, -1024,  -512,    0,  512, 1024, 1536};
  localparam int ERR_D [7] = '{-1152,  -768,     0,  128, 1024, 1536, 1536};
  // Drive sets OFF, BP, MBP, MAP, ALL.
  localparam int DRV_A [5] = '{0,     0,  7680, 15360, 25600};
  localparam int DRV_B [5] = '{0,  2560, 10240, 17920, 25600};
  localparam int DRV_C [5] = '{0,  2560, 10240, 17920, 25600};
  localparam int DRV_D [5] = '{0, 10240, 12800, 23040, 25600};
  // Consequent drive set of each error set for each pump.
  localparam int ETHANOL_RULE [7] = '{4, 3, 2, 1, 0, 0, 0};
  localparam int WATER_RULE   [7] = '{0, 0, 0, 1, 3, 2, 4};

  logic [fpc_pkg::PH_W-1:0] setpoint;
  drive_pair_t              drive_queue [$];

  // Membership of x in a triangle or trapezoid; a single-point set grades one there.
  function automatic longint membership(longint a, longint b, longint c, longint d,
                                        longint x);
    if (x < a || x > d) return 0;
    if (x >= b && x <= c) return GRADE_ONE;
    if (x < b) return ((x - a) * GRADE_ONE) / (b - a);
    return ((d - x) * GRADE_ONE) / (d - c);
  endfunction

  // Centroid of the aggregated drive shape for one pump.
  function automatic fpc_pkg::pct_t pump_centroid(bit water_pump, longint err_grade [7]);
    longint num;
    longint den;
    longint x;
    longint mu;
    longint go;
    longint m;
    int     set_idx;
    num = 0;
    den = 0;
    for (int i = 0; i < NUM_POINTS; i++) begin
      x  = (i * 25600) / (NUM_POINTS - 1);
      mu = 0;
      for (int k = 0; k < 7; k++) begin
        set_idx = water_pump ? WATER_RULE[k] : ETHANOL_RULE[k];
        go = membership(DRV_A[set_idx], DRV_B[set_idx], DRV_C[set_idx],
                        DRV_D[set_idx], x);
        m  = (err_grade[k] < go) ? err_grade[k] : go;
        if (m > mu) mu = m;
      end
      num += x * mu;
      den += mu;
    end
    if (den == 0) return '0;
    return fpc_pkg::pct_t'((num + den / 2) / den);
  endfunction

  function automatic drive_pair_t predict_drives(logic [fpc_pkg::PH_W-1:0] sp,
                                                 logic [fpc_pkg::PH_W-1:0] ph);
    longint      err;
    longint      err_grade [7];
    drive_pair_t p;
    err = longint'(sp) - longint'(ph);
    if (err > 1536) err = 1536;
    if (err < -1536) err = -1536;
    for (int k = 0; k < 7; k++)
      err_grade[k] = membership(ERR_A[k], ERR_B[k], ERR_C[k], ERR_D[k], err);
    p.ethanol = pump_centroid(1'b0, err_grade);
    p.water   = pump_centroid(1'b1, err_grade);
    return p;
  endfunction

  // Track the setpoint, queue predictions and compare result transfers.
  always @(posedge clk) begin
    drive_pair_t want;
    if (!rst_n) begin
      setpoint       <= fpc_pkg::SETPOINT_RST;
      fail_count     <= 0;
      drives_checked <= 0;
      transfers_seen <= 0;
      drives_pending <= 0;
      drive_queue.delete();
    end else begin
      if (cfg_wr_en) setpoint <= cfg_wr_data;
      transfers_seen <= transfers_seen + int'(in_valid && !in_stall)
                        + int'(out_valid && !out_stall);
      if (in_valid && !in_stall) begin
        drive_queue.push_back(predict_drives(setpoint, in_measured_ph));
      end
      if (out_valid && !out_stall) begin
        if (drive_queue.size() == 0) begin
          $display("%0t: unexpected result ethanol=%0d water=%0d", $realtime,
                   out_ethanol_power, out_water_power);
          fail_count <= fail_count + 1;
        end else begin
          want = drive_queue.pop_front();
          drives_checked <= drives_checked + 1;
          if (want.ethanol !== out_ethanol_power || want.water !== out_water_power) begin
            $display("%0t: drive mismatch expected ethanol=%0d water=%0d, got %0d %0d",
                     $realtime, want.ethanol, want.water, out_ethanol_power,
                     out_water_power);
            fail_count <= fail_count + 1;
          end
        end
      end
      drives_pending <= drive_queue.size();
    end
  end
endmodule

// ===== tb/tb.sv =====
// Testbench top for the fuzzy pH pump controller: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 30000;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [fpc_pkg::PH_W-1:0]  cfg_wr_data;
  logic                      in_valid;
  logic                      in_stall;
  logic [fpc_pkg::PH_W-1:0]  in_measured_ph;
  logic                      out_valid;
  logic                      out_stall;
  logic [fpc_pkg::PCT_W-1:0] out_ethanol_power;
  logic [fpc_pkg::PCT_W-1:0] out_water_power;
  int                        fail_count;
  int                        drives_pending;
  int                        drives_checked;
  int                        transfers_seen;
  int                        samples_sent;
  int                        setpoints_used;
  int                        stall_pct;
  bit                        long_hold;
  logic [fpc_pkg::PH_W-1:0]  cur_setpoint;

  fuzzy_ph_pump_controller dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_measured_ph(in_measured_ph),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_ethanol_power(out_ethanol_power), .out_water_power(out_water_power)
  );

  fpc_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_measured_ph(in_measured_ph),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_ethanol_power(out_ethanol_power), .out_water_power(out_water_power),
    .fail_count(fail_count), .drives_pending(drives_pending),
    .drives_checked(drives_checked), .transfers_seen(transfers_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Drive one sample and hold it until the transfer happens.
  task automatic send_sample(input logic [fpc_pkg::PH_W-1:0] ph);
    in_valid       = 1'b1;
    in_measured_ph = ph;
    do @(posedge clk); while (in_stall);
    samples_sent++;
    @(negedge clk);
  endtask

  // Sample at a given error from the current setpoint, clipped to the field.
  function automatic logic [fpc_pkg::PH_W-1:0] ph_at_error(int err);
    int ph;
    ph = int'(cur_setpoint) - err;
    if (ph < 0) ph = 0;
    if (ph > 4095) ph = 4095;
    return fpc_pkg::PH_W'(ph);
  endfunction

  // Wait for every outstanding drive, then let the block settle before a write.
  task automatic drain_and_write(input logic [fpc_pkg::PH_W-1:0] sp);
    in_valid = 1'b0;
    while (drives_pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    cfg_wr_en    = 1'b1;
    cfg_wr_data  = sp;
    cur_setpoint = sp;
    setpoints_used++;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Random samples in bursts; most near the setpoint, some anywhere.
  task automatic random_phase(input int count);
    int burst;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        if ($urandom_range(0, 3) == 0) send_sample(fpc_pkg::PH_W'($urandom));
        else send_sample(ph_at_error($urandom_range(0, 3400) - 1700));
        sent++;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 2000)) @(negedge clk);
      end
    end
  endtask

  // The receiver stalls at a changing rate, with one long hold-off.
  initial begin
    int hold_cycles;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1'b1;
        for (hold_cycles = 0; hold_cycles < 4000; hold_cycles++) @(negedge clk);
        long_hold = 1'b0;
      end
      if ($urandom_range(0, 299) == 0) stall_pct = $urandom_range(0, 2) * 40;
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Cycles with no transfer on either channel end the run.
  initial begin
    int idle_cycles;
    int last_seen;
    idle_cycles = 0;
    last_seen   = 0;
    forever begin
      @(posedge clk);
      if (transfers_seen != last_seen || cfg_wr_en) idle_cycles = 0;
      else idle_cycles++;
      last_seen = transfers_seen;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int err_points [20] = '{1536, 1500, 1408, 1280, 1152, 1024, 800, 768, 512, 128,
                            0, -64, -128, -512, -768, -1024, -1152, -1408, -1536,
                            -2500};
    logic [fpc_pkg::PH_W-1:0] setpoint_list [6] = '{12'd0, 12'd3584, 12'd4095, 12'd1536,
                                                    12'd2048, 12'd700};
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_measured_ph = '0;
    samples_sent   = 0;
    setpoints_used = 1;
    stall_pct      = 0;
    long_hold      = 1'b0;
    cur_setpoint   = fpc_pkg::SETPOINT_RST;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed: every set edge and peak at the reset setpoint, plus field extremes.
    foreach (err_points[i]) send_sample(ph_at_error(err_points[i]));
    send_sample(12'd0);
    send_sample(12'hFFF);

    // Keep offering samples while the receiver holds off.
    drain_and_write(12'd2900);
    long_hold = 1'b1;
    random_phase(40);
    foreach (setpoint_list[i]) begin
      drain_and_write(setpoint_list[i]);
      random_phase(45);
    end
    drain_and_write(fpc_pkg::PH_W'($urandom));
    random_phase(60);
    drain_and_write(fpc_pkg::PH_W'($urandom_range(0, 3584)));
    random_phase(60);

    in_valid = 1'b0;
    while (drives_pending != 0) @(negedge clk);
    repeat (1500) @(negedge clk);
    $display("Sent %0d pH samples over %0d setpoints; %0d pump drive pairs checked.",
             samples_sent, setpoints_used, drives_checked);
    if (fail_count == 0 && drives_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
